// ===== rtl/core/lpht_pkg.sv =====
// shared constants, opcode and status codes, controller/datapath command and status types
// for the linear probe hash table; no dependencies

package lpht_pkg;

  localparam int unsigned LPHT_TABLE_SIZE = 512;
  localparam int unsigned LPHT_KEY_W      = 32;
  localparam int unsigned LPHT_VAL_W      = 32;
  localparam int unsigned LPHT_OP_W       = 2;
  localparam int unsigned LPHT_STATUS_W   = 2;
  localparam int unsigned LPHT_SLOT_W     = 9;

  localparam logic [LPHT_OP_W-1:0] LPHT_OP_LOOKUP = 2'd0;
  localparam logic [LPHT_OP_W-1:0] LPHT_OP_PUT    = 2'd1;
  localparam logic [LPHT_OP_W-1:0] LPHT_OP_SET    = 2'd2;

  localparam logic [LPHT_STATUS_W-1:0] LPHT_ST_HIT  = 2'd0;
  localparam logic [LPHT_STATUS_W-1:0] LPHT_ST_MISS = 2'd1;
  localparam logic [LPHT_STATUS_W-1:0] LPHT_ST_NEW  = 2'd2;
  localparam logic [LPHT_STATUS_W-1:0] LPHT_ST_FULL = 2'd3;

  typedef struct packed {
    logic clr_step;
    logic cap;
    logic probe_start;
    logic adv;
    logic fin;
    logic fin_zero;
  } lpht_cmd_t;

  typedef struct packed {
    logic mod_done;
    logic key_zero;
    logic hit;
    logic empty;
    logic last;
    logic clr_last;
  } lpht_sts_t;

endpackage

// ===== rtl/core/lpht_ram.sv =====
// generic simple dual port ram, one write and one read port, registered read data
// no dependencies

module lpht_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/lpht_mod.sv =====
// home slot unit: key modulo table size, a mask for power-of-two sizes,
// else a reciprocal multiplication and one correction step; uses lpht_pkg

module lpht_mod import lpht_pkg::*; #(
  parameter int unsigned TableSize = LPHT_TABLE_SIZE
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [LPHT_KEY_W-1:0]        key_i,
  output logic                         done_o,
  output logic [$clog2(TableSize)-1:0] home_o
);

  localparam int unsigned IdxW   = $clog2(TableSize);
  localparam bit          IsPow2 = (TableSize & (TableSize - 1)) == 0;

  if (IsPow2) begin : g_mask
    logic [IdxW-1:0] home_q;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        home_q <= '0;
      end else if (start_i) begin
        home_q <= key_i[IdxW-1:0];
      end
    end

    assign done_o = 1'b1;
    assign home_o = home_q;
  end else begin : g_recip
    localparam int unsigned           ProdW = 2 * LPHT_KEY_W;
    localparam logic [LPHT_KEY_W-1:0] Recip = LPHT_KEY_W'((64'd1 << LPHT_KEY_W) / TableSize);
    localparam logic [LPHT_KEY_W-1:0] Size  = LPHT_KEY_W'(TableSize);

    logic [2:0]            busy_q;
    logic [LPHT_KEY_W-1:0] key_q;
    logic [ProdW-1:0]      prod_q;
    logic [LPHT_KEY_W-1:0] rem_q;
    logic [IdxW-1:0]       home_q;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        busy_q <= '0;
      end else if (start_i) begin
        busy_q <= 3'b001;
      end else begin
        busy_q <= {busy_q[1:0], 1'b0};
      end
    end

    // quotient estimate is low by at most one, so one compare and subtract finishes it
    always_ff @(posedge clk_i) begin
      if (start_i) begin
        key_q <= key_i;
      end
      if (busy_q[0]) begin
        prod_q <= ProdW'(key_q) * ProdW'(Recip);
      end
      if (busy_q[1]) begin
        rem_q <= key_q - prod_q[ProdW-1:LPHT_KEY_W] * Size;
      end
      if (busy_q[2]) begin
        if (rem_q >= Size) begin
          home_q <= IdxW'(rem_q - Size);
        end else begin
          home_q <= IdxW'(rem_q);
        end
      end
    end

    assign done_o = ~|busy_q;
    assign home_o = home_q;
  end

endmodule

// ===== rtl/core/lpht_dp.sv =====
// datapath: operand and probe registers, key and value memories, entry count, result register
// uses lpht_pkg, lpht_ram, lpht_mod

module lpht_dp import lpht_pkg::*; #(
  parameter int unsigned TableSize = LPHT_TABLE_SIZE
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  lpht_cmd_t                cmd_i,
  output lpht_sts_t                sts_o,
  input  logic [LPHT_OP_W-1:0]     opcode_i,
  input  logic [LPHT_KEY_W-1:0]    key_i,
  input  logic [LPHT_VAL_W-1:0]    value_i,
  output logic [LPHT_STATUS_W-1:0] status_o,
  output logic [LPHT_SLOT_W-1:0]   slot_o,
  output logic [LPHT_VAL_W-1:0]    found_value_o,
  output logic                     load_high_o
);

  localparam int unsigned IdxW      = $clog2(TableSize);
  localparam int unsigned CntW      = $clog2(TableSize + 1);
  localparam int unsigned LoadLimit = (TableSize * 3) / 4;

  logic [LPHT_OP_W-1:0]     op_q;
  logic [LPHT_KEY_W-1:0]    key_q;
  logic [LPHT_VAL_W-1:0]    val_q;
  logic [IdxW-1:0]          idx_q, idx_d, idx_next;
  logic [IdxW-1:0]          probes_q, probes_d;
  logic [CntW-1:0]          count_q, count_d;
  logic [LPHT_STATUS_W-1:0] status_q, status_d;
  logic [LPHT_SLOT_W-1:0]   slot_q, slot_d;
  logic [LPHT_VAL_W-1:0]    fval_q, fval_d;
  logic                     load_q, load_d;

  logic [IdxW-1:0]       home;
  logic                  mod_done;
  logic [LPHT_KEY_W-1:0] key_rd;
  logic [LPHT_VAL_W-1:0] val_rd;
  logic                  hit, empty, last;
  logic                  op_put, op_set;
  logic                  key_we, val_we, rd_en;
  logic [IdxW-1:0]       rd_addr;
  logic [LPHT_KEY_W-1:0] key_wdata;

  lpht_mod #(
    .TableSize(TableSize)
  ) u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.cap),
    .key_i  (key_i),
    .done_o (mod_done),
    .home_o (home)
  );

  assign idx_next = (idx_q == IdxW'(TableSize - 1)) ? '0 : idx_q + 1'b1;
  assign hit      = key_rd == key_q;
  assign empty    = key_rd == '0;
  assign last     = probes_q == IdxW'(TableSize - 1);
  assign op_put   = op_q == LPHT_OP_PUT;
  assign op_set   = op_q == LPHT_OP_SET;

  assign rd_en     = cmd_i.probe_start | cmd_i.adv;
  assign rd_addr   = cmd_i.probe_start ? home : idx_next;
  assign key_we    = cmd_i.clr_step | (cmd_i.fin & op_put & empty & ~hit);
  assign key_wdata = cmd_i.clr_step ? '0 : key_q;
  assign val_we    = cmd_i.fin & ((hit & (op_put | op_set)) | (empty & ~hit & op_put));

  lpht_ram #(
    .Width(LPHT_KEY_W),
    .Depth(TableSize)
  ) u_key_ram (
    .clk_i  (clk_i),
    .we_i   (key_we),
    .waddr_i(idx_q),
    .wdata_i(key_wdata),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(key_rd)
  );

  lpht_ram #(
    .Width(LPHT_VAL_W),
    .Depth(TableSize)
  ) u_val_ram (
    .clk_i  (clk_i),
    .we_i   (val_we),
    .waddr_i(idx_q),
    .wdata_i(val_q),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(val_rd)
  );

  always_comb begin
    idx_d    = idx_q;
    probes_d = probes_q;
    count_d  = count_q;
    status_d = status_q;
    slot_d   = slot_q;
    fval_d   = fval_q;
    load_d   = load_q;
    if (cmd_i.clr_step || cmd_i.adv) begin
      idx_d = idx_next;
    end
    if (cmd_i.adv) begin
      probes_d = probes_q + 1'b1;
    end
    if (cmd_i.probe_start) begin
      idx_d    = home;
      probes_d = '0;
    end
    if (cmd_i.fin_zero) begin
      status_d = LPHT_ST_MISS;
      slot_d   = '0;
      fval_d   = '0;
      load_d   = count_q > CntW'(LoadLimit);
    end
    if (cmd_i.fin) begin
      fval_d = '0;
      slot_d = LPHT_SLOT_W'(home);
      priority if (hit) begin
        slot_d = LPHT_SLOT_W'(idx_q);
        if (op_put || op_set) begin
          status_d = LPHT_ST_HIT;
        end else begin
          status_d = LPHT_ST_HIT;
          fval_d   = val_rd;
        end
      end else if (empty) begin
        slot_d = LPHT_SLOT_W'(idx_q);
        if (op_put) begin
          status_d = LPHT_ST_NEW;
          count_d  = count_q + 1'b1;
        end else begin
          status_d = LPHT_ST_MISS;
        end
      end else begin
        status_d = op_put ? LPHT_ST_FULL : LPHT_ST_MISS;
      end
      load_d = count_d > CntW'(LoadLimit);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      probes_q <= '0;
      count_q  <= '0;
    end else begin
      idx_q    <= idx_d;
      probes_q <= probes_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      op_q  <= opcode_i;
      key_q <= key_i;
      val_q <= value_i;
    end
    status_q <= status_d;
    slot_q   <= slot_d;
    fval_q   <= fval_d;
    load_q   <= load_d;
  end

  assign sts_o.mod_done = mod_done;
  assign sts_o.key_zero = key_q == '0;
  assign sts_o.hit      = hit;
  assign sts_o.empty    = empty;
  assign sts_o.last     = last;
  assign sts_o.clr_last = idx_q == IdxW'(TableSize - 1);

  assign status_o      = status_q;
  assign slot_o        = slot_q;
  assign found_value_o = fval_q;
  assign load_high_o   = load_q;

endmodule

// ===== rtl/core/lpht_ctrl.sv =====
// controller: clearing pass, operand capture, probe sequencing and result beat handshake
// uses lpht_pkg

module lpht_ctrl import lpht_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  lpht_sts_t sts_i,
  output lpht_cmd_t cmd_o
);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_MOD   = 2'd2;
  localparam logic [1:0] S_CHECK = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free = ~out_valid_q | out_ready_i;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.cap = 1'b1;
          state_d   = S_MOD;
        end
      end
      S_MOD: begin
        if (sts_i.mod_done) begin
          if (sts_i.key_zero) begin
            if (out_free) begin
              cmd_o.fin_zero = 1'b1;
              state_d        = S_IDLE;
            end
          end else begin
            cmd_o.probe_start = 1'b1;
            state_d           = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (sts_i.hit || sts_i.empty || sts_i.last) begin
          if (out_free) begin
            cmd_o.fin = 1'b1;
            state_d   = S_IDLE;
          end
        end else begin
          cmd_o.adv = 1'b1;
        end
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.fin || cmd_o.fin_zero) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/core/linear_probe_hash_table.sv =====
// Key/value table with open addressing and linear probing. After reset the block
// clears the key memory (s_axis_tready stays low), then takes one operation at a
// time, reading the key and value memories once per probe; for table sizes that
// are not a power of two the home slot comes from a reciprocal multiplication with
// one correction step. The result sits in an output register, so the next
// operation is accepted while the previous result beat still waits. Key zero is the
// empty mark and always answers not found at slot 0.
// top level; uses lpht_pkg, lpht_ctrl, lpht_dp

module linear_probe_hash_table import lpht_pkg::*; #(
  parameter int unsigned TableSize = LPHT_TABLE_SIZE
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // opcode[1:0], key[33:2], value[65:34], zero[71:66]
  input  logic [71:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[1:0], slot[10:2], found_value[42:11], load_high[43], zero[47:44]
  output logic [47:0] m_axis_tdata
);

  lpht_cmd_t cmd;
  lpht_sts_t sts;

  logic [LPHT_STATUS_W-1:0] status;
  logic [LPHT_SLOT_W-1:0]   slot;
  logic [LPHT_VAL_W-1:0]    found_value;
  logic                     load_high;

  lpht_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lpht_dp #(
    .TableSize(TableSize)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .opcode_i     (s_axis_tdata[1:0]),
    .key_i        (s_axis_tdata[33:2]),
    .value_i      (s_axis_tdata[65:34]),
    .status_o     (status),
    .slot_o       (slot),
    .found_value_o(found_value),
    .load_high_o  (load_high)
  );

  assign m_axis_tdata = {4'b0000, load_high, found_value, slot, status};

endmodule
